>>> rtl/rrm_pkg.sv
`default_nettype none
package rrm_pkg;

  localparam int FRAMES_DEF = 32;
  localparam int MAX_ROWS   = 2048;

  localparam int Y_W   = 11;
  localparam int H_W   = 12;
  localparam int FRM_W = 16;
  localparam int TOP_W = 13;
  localparam int DST_W = 14;
  localparam int ANG_W = 27;

  localparam logic [ANG_W-1:0] PI_Q24      = 27'd52707179;
  localparam logic [ANG_W-1:0] TWO_PI_Q24  = 27'd105414358;
  localparam logic [ANG_W-1:0] HALF_PI_Q24 = 27'd26353589;
  localparam logic [24:0]      ONE_Q24     = 25'h100_0000;
  localparam logic [16:0]      SINE_ONE    = 17'd65536;

  localparam int HORNER_N  = 5;
  localparam int HORNER_SH = 33;
  localparam logic [30:0] HORNER_RCP [HORNER_N] = '{
    31'(((64'd1 << HORNER_SH) + 64'd109) / 64'd110),
    31'(((64'd1 << HORNER_SH) + 64'd71) / 64'd72),
    31'(((64'd1 << HORNER_SH) + 64'd41) / 64'd42),
    31'(((64'd1 << HORNER_SH) + 64'd19) / 64'd20),
    31'(((64'd1 << HORNER_SH) + 64'd5) / 64'd6)
  };

  // x/40 = (x*RCP)>>21, x/10 = >>19, x/5 = >>18
  localparam logic [15:0] GRAIN_RCP = 16'd52429;
  localparam logic [21:0] FIFTH_RCP_A = 22'(((64'd1 << 24) + 64'd4) / 64'd5);
  localparam logic [22:0] FIFTH_RCP_B = 23'(((64'd1 << 25) + 64'd4) / 64'd5);

  localparam logic [9:0]  RIPPLE_GAIN = 10'd5;
  localparam logic [11:0] WAVE_HEIGHT = 12'd100;

  typedef enum logic [1:0] {
    REG_HEIGHT = 2'd0,
    REG_FRAME  = 2'd1,
    REG_TOP    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [H_W-1:0]          h;
    logic [6:0]              rip;
    logic [9:0]              rip5;
    logic [8:0]              h10;
    logic [9:0]              h5;
    logic [ANG_W-1:0]        phase;
    logic signed [TOP_W-1:0] top;
  } cfg_t;

  typedef struct packed {
    logic [H_W-1:0]          source_row;
    logic signed [DST_W-1:0] dest_row;
    logic                    row_drawn;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/ripple_reflection_row_map.sv
`default_nettype none
// Throughput: one word per cycle unless a skid word is held or config is busy;
// the output stage plus a skid word absorb an output stall. A config write
// holds input off while frame mod FRAMES and the phase are recomputed by
// reciprocal multiplication.
// Reset: height 1, frame 0, top 0, phase 0, pipeline and output empty.
module ripple_reflection_row_map #(
  parameter int FRAMES = rrm_pkg::FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // row[10:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // source_row[11:0], dest_row[25:12]
  output logic        m_tuser,   // row_drawn
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rrm_pkg::*;

  localparam int FW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int BW     = 2 * FW;
  localparam int RCP_SH = 30;
  localparam logic [30:0] FR_RCP =
      31'(((64'd1 << RCP_SH) + 64'(FRAMES) - 64'd1) / 64'(FRAMES));
  localparam logic [ANG_W-1:0] PH_A = ANG_W'(64'(TWO_PI_Q24) / 64'(FRAMES));
  localparam logic [FW-1:0]    PH_B = FW'(64'(TWO_PI_Q24) % 64'(FRAMES));

  typedef enum logic [2:0] {ST_IDLE, ST_LOADF, ST_MODF, ST_LOADP, ST_DIVP} st_t;

  logic [H_W-1:0]          hgt;
  logic [FRM_W-1:0]        frm;
  logic signed [TOP_W-1:0] top_r;
  logic                    cfg_wr;
  logic                    busy;
  logic                    en;

  st_t              state;
  logic [15:0]      fq;
  logic [FW-1:0]    fm;
  logic [BW-1:0]    bf;
  logic [ANG_W-1:0] af;
  logic [ANG_W-1:0] phase;

  logic [46:0] fq_p;
  logic [31:0] fr_p;
  logic [50:0] bq_p;

  assign busy      = state != ST_IDLE;
  assign cfg_ready = !busy && !rst;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hgt   <= 12'd1;
      frm   <= '0;
      top_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_index))
        REG_HEIGHT: hgt   <= cfg_data[H_W-1:0];
        REG_FRAME:  frm   <= cfg_data[FRM_W-1:0];
        REG_TOP:    top_r <= $signed(cfg_data[TOP_W-1:0]);
        default: ;
      endcase
    end
  end

  assign fq_p = 47'(frm) * 47'(FR_RCP);
  assign fr_p = 32'(frm) - 32'(fq) * 32'(FRAMES);
  assign bq_p = 51'(bf) * 51'(FR_RCP);

  // frame mod FRAMES, then 2*pi*f/FRAMES
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= '0;
      fq    <= '0;
      fm    <= '0;
      bf    <= '0;
      af    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cfg_wr) state <= ST_LOADF;
        end
        ST_LOADF: begin
          fq    <= 16'(fq_p >> RCP_SH);
          state <= ST_MODF;
        end
        ST_MODF: begin
          fm    <= FW'(fr_p);
          state <= ST_LOADP;
        end
        ST_LOADP: begin
          bf    <= BW'(PH_B) * BW'(fm);
          af    <= PH_A * ANG_W'(fm);
          state <= ST_DIVP;
        end
        ST_DIVP: begin
          phase <= af + ANG_W'(bq_p >> RCP_SH);
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // height-derived values
  logic [H_W-1:0] hc;
  logic [27:0]    hp;
  cfg_t           cfg_q;

  assign hc = (hgt == '0) ? 12'd1
            : ((15'(hgt) > 15'(MAX_ROWS)) ? 12'(MAX_ROWS) : hgt);
  assign hp = 28'(hc) * 28'(GRAIN_RCP);

  always_ff @(posedge clk) begin
    cfg_q.h    <= hc;
    cfg_q.rip  <= 7'(hp >> 21);
    cfg_q.rip5 <= 10'(7'(hp >> 21)) * RIPPLE_GAIN;
    cfg_q.h10  <= 9'(hp >> 19);
    cfg_q.h5   <= 10'(hp >> 18);
    cfg_q.phase <= phase;
    cfg_q.top  <= top_r;
  end

  // pipeline
  logic skv;
  logic pv;
  res_t pres;
  res_t skp;
  res_t op;

  assign en       = !skv;
  assign s_tready = en && !busy && !rst;

  rrm_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid && s_tready),
    .in_row    (s_tdata[Y_W-1:0]),
    .cfg       (cfg_q),
    .out_valid (pv),
    .out_res   (pres)
  );

  // output word and skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skv      <= 1'b0;
    end else if (m_tvalid && !m_tready) begin
      if (!skv && pv) skv <= 1'b1;
    end else if (skv) begin
      m_tvalid <= 1'b1;
      skv      <= 1'b0;
    end else begin
      m_tvalid <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && !m_tready) begin
      if (!skv) skp <= pres;
    end else if (skv) begin
      op <= skp;
    end else begin
      op <= pres;
    end
  end

  assign m_tdata = {6'b0, op.dest_row, op.source_row};
  assign m_tuser = op.row_drawn;

`ifndef SYNTHESIS
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_tready)
    else $error("input open right after config write");
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skv |-> m_tvalid)
    else $error("skid word without output word");
  a_source_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[11:0] != 12'd0)
    else $error("source row out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/rrm_pipe.sv
`default_nettype none
module rrm_pipe (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [rrm_pkg::Y_W-1:0] in_row,
  input  rrm_pkg::cfg_t           cfg,
  output logic                    out_valid,
  output rrm_pkg::res_t           out_res
);
  import rrm_pkg::*;

  localparam int MAG_W = 21;
  localparam int DA_N  = MAG_W + 24;
  localparam int DB_N  = 20;
  localparam int HS    = 2 * HORNER_N;

  // entry
  logic           v0;
  logic [Y_W-1:0] y0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) y0 <= in_row;
  end

  // angle divider
  logic             dav [DA_N+1];
  logic [11:0]      dar [DA_N+1];
  logic [ANG_W-1:0] daa [DA_N+1];
  logic [MAG_W-1:0] dam [DA_N+1];
  logic [11:0]      dad [DA_N+1];
  logic             dan [DA_N+1];
  logic [Y_W-1:0]   day [DA_N+1];

  logic signed [12:0] hy;
  logic [11:0]        hy_mag;
  logic [18:0]        rm;

  assign hy     = $signed({1'b0, cfg.h}) - $signed({2'b00, y0});
  assign hy_mag = hy[12] ? 12'(-hy) : hy[11:0];
  assign rm     = 19'(cfg.rip) * 19'(hy_mag);

  always_ff @(posedge clk) begin
    if (rst) dav[0] <= 1'b0;
    else if (en) dav[0] <= v0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dar[0] <= '0;
      daa[0] <= '0;
      dam[0] <= {rm, 2'b00};
      dad[0] <= 12'(y0) + 12'd1;
      dan[0] <= hy[12];
      day[0] <= y0;
    end
  end

  for (genvar k = 0; k < DA_N; k++) begin : g_da
    logic [12:0]      r2;
    logic             ge;
    logic [11:0]      rn;
    logic [ANG_W:0]   a2;
    logic [ANG_W-1:0] an;

    assign r2 = {dar[k], dam[k][MAG_W-1]};
    assign ge = r2 >= {1'b0, dad[k]};
    assign rn = ge ? 12'(r2 - {1'b0, dad[k]}) : r2[11:0];
    assign a2 = {daa[k], ge};
    assign an = (a2 >= {1'b0, TWO_PI_Q24}) ? ANG_W'(a2 - {1'b0, TWO_PI_Q24}) : a2[ANG_W-1:0];

    always_ff @(posedge clk) begin
      if (rst) dav[k+1] <= 1'b0;
      else if (en) dav[k+1] <= dav[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dar[k+1] <= rn;
        daa[k+1] <= an;
        dam[k+1] <= {dam[k][MAG_W-2:0], 1'b0};
        dad[k+1] <= dad[k];
        dan[k+1] <= dan[k];
        day[k+1] <= day[k];
      end
    end
  end

  // add phase, wrap
  logic [ANG_W:0]   pa_add;
  logic [ANG_W:0]   pa_sub;
  logic [ANG_W-1:0] ang_c;
  logic             v2;
  logic [ANG_W-1:0] ang2;
  logic [Y_W-1:0]   y2;

  assign pa_add = {1'b0, cfg.phase} + {1'b0, daa[DA_N]};
  assign pa_sub = {1'b0, cfg.phase} - {1'b0, daa[DA_N]};
  assign ang_c  = dan[DA_N]
      ? (pa_sub[ANG_W] ? ANG_W'(pa_sub + {1'b0, TWO_PI_Q24}) : pa_sub[ANG_W-1:0])
      : ((pa_add >= {1'b0, TWO_PI_Q24}) ? ANG_W'(pa_add - {1'b0, TWO_PI_Q24})
                                        : pa_add[ANG_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= dav[DA_N];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ang2 <= ang_c;
      y2   <= day[DA_N];
    end
  end

  // fold into first quadrant
  logic             sg_c;
  logic [ANG_W-1:0] fb;
  logic [ANG_W-1:0] fx;
  logic             v3;
  logic [24:0]      x3;
  logic             sg3;
  logic [Y_W-1:0]   y3;

  assign sg_c = ang2 >= PI_Q24;
  assign fb   = sg_c ? ang2 - PI_Q24 : ang2;
  assign fx   = (fb > HALF_PI_Q24) ? PI_Q24 - fb : fb;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x3  <= fx[24:0];
      sg3 <= sg_c;
      y3  <= y2;
    end
  end

  // series
  logic        hv   [HS+1];
  logic [25:0] hx2  [HS+1];
  logic [24:0] hx   [HS+1];
  logic        hsg  [HS+1];
  logic [Y_W-1:0] hyy [HS+1];
  logic [25:0] hval [HS+1];
  logic [49:0] xx;

  assign xx = 50'(x3) * 50'(x3);

  always_ff @(posedge clk) begin
    if (rst) hv[0] <= 1'b0;
    else if (en) hv[0] <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      hx2[0]  <= xx[49:24];
      hx[0]   <= x3;
      hsg[0]  <= sg3;
      hyy[0]  <= y3;
      hval[0] <= '0;
    end
  end

  for (genvar i = 0; i < HORNER_N; i++) begin : g_hr
    logic [24:0] t_in;
    logic [50:0] pm;
    logic [56:0] qm;

    if (i == 0) begin : g_t0
      assign t_in = ONE_Q24;
    end else begin : g_tn
      assign t_in = ONE_Q24 - 25'(hval[2*i]);
    end
    assign pm = 51'(hx2[2*i]) * 51'(t_in);
    assign qm = 57'(hval[2*i+1]) * 57'(HORNER_RCP[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        hv[2*i+1] <= 1'b0;
        hv[2*i+2] <= 1'b0;
      end else if (en) begin
        hv[2*i+1] <= hv[2*i];
        hv[2*i+2] <= hv[2*i+1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        hval[2*i+1] <= pm[49:24];
        hx2[2*i+1]  <= hx2[2*i];
        hx[2*i+1]   <= hx[2*i];
        hsg[2*i+1]  <= hsg[2*i];
        hyy[2*i+1]  <= hyy[2*i];
        hval[2*i+2] <= 26'(qm[56:HORNER_SH]);
        hx2[2*i+2]  <= hx2[2*i+1];
        hx[2*i+2]   <= hx[2*i+1];
        hsg[2*i+2]  <= hsg[2*i+1];
        hyy[2*i+2]  <= hyy[2*i+1];
      end
    end
  end

  // sine magnitude, Q16
  logic [24:0]    t5;
  logic [49:0]    st;
  logic           v4;
  logic [16:0]    sq;
  logic           sg4;
  logic [Y_W-1:0] y4;

  assign t5 = ONE_Q24 - 25'(hval[HS]);
  assign st = 50'(hx[HS]) * 50'(t5);

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= hv[HS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq  <= (st[49:32] > 18'(SINE_ONE)) ? SINE_ONE : 17'(st[49:32]);
      sg4 <= hsg[HS];
      y4  <= hyy[HS];
    end
  end

  // displacement numerator
  logic           v5;
  logic [26:0]    rs;
  logic           sg5;
  logic [Y_W-1:0] y5;
  logic [38:0]    nf;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rs  <= 27'(cfg.rip5) * 27'(sq);
      sg5 <= sg4;
      y5  <= y4;
    end
  end

  assign nf = 39'(rs) * 39'(12'(y5) + WAVE_HEIGHT);

  // displacement divider
  logic            dbv [DB_N+1];
  logic [11:0]     dbr [DB_N+1];
  logic [DB_N-1:0] dbq [DB_N+1];
  logic            dbs [DB_N+1];
  logic [Y_W-1:0]  dby [DB_N+1];

  always_ff @(posedge clk) begin
    if (rst) dbv[0] <= 1'b0;
    else if (en) dbv[0] <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dbr[0] <= '0;
      dbq[0] <= nf[36:17];
      dbs[0] <= sg5;
      dby[0] <= y5;
    end
  end

  for (genvar k = 0; k < DB_N; k++) begin : g_db
    logic [12:0] r2;
    logic        ge;

    assign r2 = {dbr[k], dbq[k][DB_N-1]};
    assign ge = r2 >= {1'b0, cfg.h};

    always_ff @(posedge clk) begin
      if (rst) dbv[k+1] <= 1'b0;
      else if (en) dbv[k+1] <= dbv[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dbr[k+1] <= ge ? 12'(r2 - {1'b0, cfg.h}) : r2[11:0];
        dbq[k+1] <= {dbq[k][DB_N-2:0], ge};
        dbs[k+1] <= dbs[k];
        dby[k+1] <= dby[k];
      end
    end
  end

  // damping
  logic [20:0]     q2;
  logic [42:0]     pa;
  logic            v6;
  logic [DB_N-1:0] dm1;
  logic            sg6;
  logic [Y_W-1:0]  y6;
  logic [21:0]     q3;
  logic [44:0]     pb;
  logic            v7;
  logic [DB_N-1:0] dm2;
  logic            sg7;
  logic [Y_W-1:0]  y7;

  assign q2 = {dbq[DB_N], 1'b0};
  assign pa = 43'(q2) * 43'(FIFTH_RCP_A);

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= dbv[DB_N];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dm1 <= ({1'b0, dby[DB_N]} < 12'(cfg.h10)) ? 20'(pa[42:24]) : dbq[DB_N];
      sg6 <= dbs[DB_N];
      y6  <= dby[DB_N];
    end
  end

  assign q3 = {1'b0, dm1, 1'b0} + {2'b00, dm1};
  assign pb = 45'(q3) * 45'(FIFTH_RCP_B);

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dm2 <= ({1'b0, y6} < 12'(cfg.h5)) ? pb[44:25] : dm1;
      sg7 <= sg6;
      y7  <= y6;
    end
  end

  // source line, clamp, destination
  logic [20:0] yy;
  logic [20:0] raw;
  logic [20:0] hm1;
  logic [20:0] src;
  logic [14:0] ds;

  assign yy  = 21'(y7);
  assign raw = sg7 ? yy + 21'(dm2) : ((yy < 21'(dm2)) ? yy : yy - 21'(dm2));
  assign hm1 = 21'(cfg.h) - 21'd1;
  assign src = (raw > hm1) ? hm1 : raw;
  assign ds  = 15'(cfg.top) + 15'(y7) + 15'(cfg.h) - 15'd2;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_res.source_row <= 12'(21'(cfg.h) - src);
      out_res.dest_row   <= ds[DST_W-1:0];
      out_res.row_drawn  <= (y7 != '0) && ({1'b0, y7} < cfg.h);
    end
  end

endmodule
`default_nettype wire

>>> tb/ripple_reflection_row_map_test.sv
`timescale 1ns / 1ps
module ripple_reflection_row_map_test;
  import rrm_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint PI_Q = 52707179;
  localparam longint TWO_PI_Q = 2 * PI_Q;
  localparam longint HALF_PI_Q = PI_Q / 2;
  localparam longint ONE_Q = 64'd16777216;
  localparam longint SINE_UNIT = 65536;
  localparam int N_FRAMES = 32;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  longint height_reg;
  longint frame_reg;
  longint top_reg;
  res_t   row_map_q[$];
  int     error_count = 0;
  int     cycle_count = 0;
  bit     no_idle = 1'b0;

  ripple_reflection_row_map i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) m_tready <= no_idle || ($urandom_range(99) >= 28);

  function automatic longint ripple_sine(longint arg);
    longint a, x2, t, s;
    longint divs[5];
    bit neg;
    divs = '{110, 72, 42, 20, 6};
    neg = 1'b0;
    a = arg % TWO_PI_Q;
    if (a < 0) a += TWO_PI_Q;
    if (a >= PI_Q) begin
      neg = 1'b1;
      a -= PI_Q;
    end
    if (a > HALF_PI_Q) a = PI_Q - a;
    x2 = (a * a) >>> 24;
    t = ONE_Q;
    for (int i = 0; i < 5; i++) t = ONE_Q - (((x2 * t) >>> 24) / divs[i]);
    s = ((a * t) >>> 24) >>> 8;
    if (s > SINE_UNIT) s = SINE_UNIT;
    return neg ? -s : s;
  endfunction

  function automatic res_t map_row(longint y);
    longint h, rip, phase, arg, disp, src, dst;
    res_t r;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MAX_ROWS) h = MAX_ROWS;
    rip = h / 40;
    phase = TWO_PI_Q * (frame_reg % N_FRAMES) / N_FRAMES;
    arg = (rip * (h - y) * 4 * ONE_Q) / (y + 1) + phase;
    disp = (rip * 5 * ripple_sine(arg) * (y + 100)) / (2 * h * SINE_UNIT);
    if (y < h / 10) disp = disp * 2 / 5;
    if (y < h / 5) disp = disp * 3 / 5;
    src = (y < disp) ? y : y - disp;
    if (src > h - 1) src = h - 1;
    if (src < 0) src = 0;
    dst = top_reg + y + h - 2;
    r.source_row = H_W'(h - src);
    r.dest_row = DST_W'(dst);
    r.row_drawn = (y >= 1) && (y < h);
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    error_count++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  always @(negedge clk) begin
    res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (row_map_q.size() == 0) begin
        report("unexpected word", m_tdata, 0);
      end else begin
        e = row_map_q.pop_front();
        if (m_tdata[11:0] !== e.source_row) report("source_row", m_tdata[11:0], e.source_row);
        if (m_tdata[25:12] !== e.dest_row) report("dest_row", m_tdata[25:12], e.dest_row);
        if (m_tuser !== e.row_drawn) report("row_drawn", m_tuser, e.row_drawn);
      end
    end
  end

  task automatic send_row(logic [10:0] y);
    while (!no_idle && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, y};
    do @(negedge clk); while (!s_tready);
    row_map_q.push_back(map_row(y));
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (row_map_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HEIGHT: height_reg = value[11:0];
      REG_FRAME:  frame_reg = value;
      REG_TOP:    top_reg = longint'($signed(value[12:0]));
      default: ;
    endcase
  endtask

  task automatic test_reset_state();
    send_row(11'd0);
    send_row(11'd1);
    send_row(11'd2047);
  endtask

  task automatic test_directed();
    write_reg(REG_HEIGHT, 16'd40);
    write_reg(REG_FRAME, 16'd5);
    send_row(11'd0); send_row(11'd1); send_row(11'd3); send_row(11'd8);
    send_row(11'd39); send_row(11'd40); send_row(11'd2047);
    write_reg(REG_HEIGHT, 16'd0);
    send_row(11'd0); send_row(11'd1);
    write_reg(REG_HEIGHT, 16'hFFFF);
    write_reg(REG_TOP, 16'h1000);
    send_row(11'd0); send_row(11'd204); send_row(11'd409); send_row(11'd2047);
    write_reg(REG_TOP, 16'hEFFF);
    write_reg(REG_FRAME, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h0123);
    send_row(11'd1); send_row(11'd1000); send_row(11'd2047);
  endtask

  task automatic test_random();
    int h;
    for (int p = 0; p < 13; p++) begin
      case ($urandom_range(5))
        0: write_reg(REG_HEIGHT, 16'($urandom_range(1, 2048)) | 16'($urandom_range(15) << 12));
        1: write_reg(REG_HEIGHT, 16'd2048);
        2: write_reg(REG_HEIGHT, 16'($urandom_range(1, 80)));
        default: write_reg(REG_HEIGHT, 16'($urandom_range(40, 600)));
      endcase
      write_reg(REG_FRAME, 16'($urandom));
      write_reg(REG_TOP, 16'($urandom));
      h = int'((height_reg < 1) ? 1 : (height_reg > MAX_ROWS) ? MAX_ROWS : height_reg);
      no_idle = (p == 6);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(9) < 8) send_row(11'($urandom_range(0, h)));
        else send_row(11'($urandom));
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    height_reg = 1;
    frame_reg = 0;
    top_reg = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_random();
    drain();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rrm_pkg.sv
rtl/rrm_pipe.sv
rtl/ripple_reflection_row_map.sv
tb/ripple_reflection_row_map_test.sv
